[design/piaw_pkg.sv]
// ----------------------------------------------------------------------------
// piaw_pkg
// Shared widths, fixed-point constants, codes and control types of the
// PI controller with clamping anti-windup.
// ----------------------------------------------------------------------------
package piaw_pkg;

    // field widths
    localparam int VOLT_W  = 24;               // Q8.16 signed voltages
    localparam int GAIN_W  = 32;               // Q8.24 gains, Q0.32 time step
    localparam int ERR_W   = VOLT_W + 1;       // Q9.16 signed error
    localparam int INTEG_W = 64;               // Q24.40 signed integral
    localparam int DUTY_W  = 17;               // Q1.16, 65536 is full duty
    localparam int LIM_W   = 2;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd3;

    localparam logic [VOLT_W-1:0] RESET_REFERENCE = 24'd786432;
    localparam logic [GAIN_W-1:0] RESET_KP        = 32'd167772;
    localparam logic [GAIN_W-1:0] RESET_KI        = 32'd1677722;
    localparam logic [GAIN_W-1:0] RESET_TIME_STEP = 32'd214748;

    // serial multiplier: signed multiplicand times unsigned multiplier
    localparam int MCAND_W = 33;
    localparam int MPLR_W  = GAIN_W;
    localparam int ACC_W   = MCAND_W + 1;
    localparam int PROD_W  = ACC_W + MPLR_W;

    // fixed-point limits in Q.40
    localparam logic signed [INTEG_W-1:0] ONE_Q40    = 64'sh0000_0100_0000_0000;
    localparam logic signed [INTEG_W-1:0] SAT_POS    = 64'sh4000_0000_0000_0000;
    localparam logic signed [INTEG_W-1:0] SAT_NEG    = -64'sh4000_0000_0000_0000;
    localparam logic signed [INTEG_W-1:0] PROD_LIMIT = 64'sh0040_0000_0000_0000;
    localparam logic [INTEG_W-1:0] INTEG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [INTEG_W-1:0] INTEG_MIN = 64'h8000_0000_0000_0000;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 17'h10000;
    localparam logic [DUTY_W-1:0] DUTY_ZERO = 17'h00000;

    localparam logic [LIM_W-1:0] LIM_NONE = 2'd0;
    localparam logic [LIM_W-1:0] LIM_HIGH = 2'd1;
    localparam logic [LIM_W-1:0] LIM_LOW  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TS_GO,
        ST_TS_RUN,
        ST_INTEG,
        ST_LO_GO,
        ST_LO_RUN,
        ST_HI_GO,
        ST_HI_RUN,
        ST_KP_GO,
        ST_KP_RUN,
        ST_DECIDE
    } state_t;

    // operand pairs for the shared multiplier
    typedef enum logic [1:0] {
        OP_ERR_TS,
        OP_LO_KI,
        OP_HI_KI,
        OP_ERR_KP
    } op_sel_t;

    typedef struct packed {
        logic    in_ready;
        logic    mult_start;
        op_sel_t op_sel;
        logic    integ_load;
        logic    sum_lo_load;
        logic    sum_hi_load;
        logic    sum_kp_load;
        logic    finish;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic mult_busy;
        logic out_free;
    } seq_stat_t;

endpackage

[design/piaw_serial_mult.sv]
// ----------------------------------------------------------------------------
// piaw_serial_mult
// Shift-add multiplier: one multiplier bit per cycle, signed multiplicand
// times unsigned multiplier, full-width product.
// ----------------------------------------------------------------------------
module piaw_serial_mult (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [piaw_pkg::MCAND_W-1:0]    mcand,
    input  logic [piaw_pkg::MPLR_W-1:0]     mplr,
    output logic [piaw_pkg::PROD_W-1:0]     product,
    output logic                            busy
);
    import piaw_pkg::*;

    localparam int CNT_W = $clog2(MPLR_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MCAND_W-1:0] mcand_reg, mcand_next;
    logic [ACC_W-1:0]   upper_reg, upper_next;
    logic [MPLR_W-1:0]  lower_reg, lower_next;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W-1:0]   psum;

    always_comb begin
        addend = lower_reg[0] ? {mcand_reg[MCAND_W-1], mcand_reg} : '0;
        psum   = upper_reg + addend;
    end

    always_comb begin
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        upper_next = upper_reg;
        lower_next = lower_reg;
        if (start) begin
            cnt_next   = CNT_W'(MPLR_W);
            mcand_next = mcand;
            upper_next = '0;
            lower_next = mplr;
        end else if (cnt_reg != '0) begin
            // add then shift the pair right, product bits fall into lower
            cnt_next   = cnt_reg - CNT_W'(1);
            upper_next = {psum[ACC_W-1], psum[ACC_W-1:1]};
            lower_next = {psum[0], lower_reg[MPLR_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg <= mcand_next;
        upper_reg <= upper_next;
        lower_reg <= lower_next;
    end

    assign product = {upper_reg, lower_reg};
    assign busy    = (cnt_reg != '0);

endmodule

[design/piaw_seq.sv]
// ----------------------------------------------------------------------------
// piaw_seq
// Sequencer: walks one sample through the four serial products, the
// integral update and the clamp decision.
// ----------------------------------------------------------------------------
module piaw_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  piaw_pkg::seq_stat_t   stat,
    output piaw_pkg::ctrl_t       ctrl,
    output piaw_pkg::state_t      state
);
    import piaw_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (stat.in_valid) state_next = ST_TS_GO;
            ST_TS_GO:  state_next = ST_TS_RUN;
            ST_TS_RUN: if (!stat.mult_busy) state_next = ST_INTEG;
            ST_INTEG:  state_next = ST_LO_GO;
            ST_LO_GO:  state_next = ST_LO_RUN;
            ST_LO_RUN: if (!stat.mult_busy) state_next = ST_HI_GO;
            ST_HI_GO:  state_next = ST_HI_RUN;
            ST_HI_RUN: if (!stat.mult_busy) state_next = ST_KP_GO;
            ST_KP_GO:  state_next = ST_KP_RUN;
            ST_KP_RUN: if (!stat.mult_busy) state_next = ST_DECIDE;
            ST_DECIDE: if (stat.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        ctrl.op_sel = OP_ERR_TS;
        case (state_reg)
            ST_IDLE:   ctrl.in_ready = 1'b1;
            ST_TS_GO: begin
                ctrl.mult_start = 1'b1;
                ctrl.op_sel     = OP_ERR_TS;
            end
            ST_INTEG:  ctrl.integ_load = 1'b1;
            ST_LO_GO: begin
                ctrl.mult_start = 1'b1;
                ctrl.op_sel     = OP_LO_KI;
            end
            ST_LO_RUN: ctrl.sum_lo_load = !stat.mult_busy;
            ST_HI_GO: begin
                ctrl.mult_start = 1'b1;
                ctrl.op_sel     = OP_HI_KI;
            end
            ST_HI_RUN: ctrl.sum_hi_load = !stat.mult_busy;
            ST_KP_GO: begin
                ctrl.mult_start = 1'b1;
                ctrl.op_sel     = OP_ERR_KP;
            end
            ST_KP_RUN: ctrl.sum_kp_load = !stat.mult_busy;
            ST_DECIDE: ctrl.finish = stat.out_free;
            default:   ctrl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

[design/pi_controller_antiwindup_unit.sv]
// ----------------------------------------------------------------------------
// pi_controller_antiwindup_unit
// Fixed-point PI voltage controller with clamping anti-windup.
// ----------------------------------------------------------------------------
// Each item is one measured voltage; each gives one duty item. The block
// takes an item, then works on it before it takes the next: the error
// times time step, the low and high halves of the integral times the
// integral gain and the error times the proportional gain each go through
// one shared shift-add multiplier at one bit per cycle, plus a step each
// for the integral update, the clamp decision and the idle/accept state. A
// finished duty item waits in the output register while the next
// measurement is taken in. If the output is still held when the next duty
// is ready, the block waits in its decide step. The integral saturates at
// the signed 64-bit limits and is restored whenever the duty clamps.
// ----------------------------------------------------------------------------
module pi_controller_antiwindup_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_we,
    input  logic [piaw_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [piaw_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // measurement stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [piaw_pkg::TDATA_IN_W-1:0]      s_tdata,   // [23:0] measured_voltage
    // duty stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [piaw_pkg::TDATA_OUT_W-1:0]     m_tdata,   // [16:0] duty_cycle, [23:17] zero
    output logic [piaw_pkg::LIM_W-1:0]           m_tuser    // [1:0] limit_hit
);
    import piaw_pkg::*;

    ctrl_t     ctrl;
    seq_stat_t stat;
    state_t    state;

    logic [VOLT_W-1:0]  ref_reg, ref_next;
    logic [GAIN_W-1:0]  kp_reg, kp_next;
    logic [GAIN_W-1:0]  ki_reg, ki_next;
    logic [GAIN_W-1:0]  ts_reg, ts_next;

    logic [ERR_W-1:0]   err_reg, err_next;
    logic [INTEG_W-1:0] integ_reg, integ_next;
    logic [INTEG_W-1:0] integ_try_reg, integ_try_next;
    logic [INTEG_W-1:0] sum_reg, sum_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [LIM_W-1:0]   lim_reg, lim_next;

    logic [MCAND_W-1:0] mcand;
    logic [MPLR_W-1:0]  mplr;
    logic [PROD_W-1:0]  product;
    logic               mult_busy;

    logic [INTEG_W-1:0] incr;
    logic [INTEG_W:0]   integ_sum;
    logic               sum_above_one;
    logic               sum_negative;

    piaw_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl),
        .state   (state)
    );

    piaw_serial_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.mult_start),
        .mcand   (mcand),
        .mplr    (mplr),
        .product (product),
        .busy    (mult_busy)
    );

    always_comb begin
        stat.in_valid  = s_tvalid;
        stat.mult_busy = mult_busy;
        stat.out_free  = !m_tvalid_reg || m_tready;
    end

    // operand selection for the shared multiplier
    always_comb begin
        case (ctrl.op_sel)
            OP_ERR_TS: begin
                mcand = {{(MCAND_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mplr  = ts_reg;
            end
            OP_LO_KI: begin
                mcand = {1'b0, integ_try_reg[31:0]};
                mplr  = ki_reg;
            end
            OP_HI_KI: begin
                mcand = {integ_try_reg[INTEG_W-1], integ_try_reg[INTEG_W-1:32]};
                mplr  = ki_reg;
            end
            OP_ERR_KP: begin
                mcand = {{(MCAND_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mplr  = kp_reg;
            end
            default: begin
                mcand = '0;
                mplr  = '0;
            end
        endcase
    end

    // configuration writes
    always_comb begin
        ref_next = ref_reg;
        kp_next  = kp_reg;
        ki_next  = ki_reg;
        ts_next  = ts_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_REFERENCE: ref_next = cfg_wdata[VOLT_W-1:0];
                REG_KP:        kp_next  = cfg_wdata[GAIN_W-1:0];
                REG_KI:        ki_next  = cfg_wdata[GAIN_W-1:0];
                REG_TIME_STEP: ts_next  = cfg_wdata[GAIN_W-1:0];
                default:       ref_next = ref_reg;
            endcase
        end
    end

    // integral increment is floor(err * ts / 2^8); the add saturates
    always_comb begin
        incr      = {{8{product[63]}}, product[63:8]};
        integ_sum = {integ_reg[INTEG_W-1], integ_reg} + {incr[INTEG_W-1], incr};
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_try_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_try_next = integ_sum[INTEG_W-1:0];
        end
        if (!ctrl.integ_load) begin
            integ_try_next = integ_try_reg;
        end
    end

    always_comb begin
        err_next = err_reg;
        if (ctrl.in_ready && s_tvalid) begin
            err_next = {ref_reg[VOLT_W-1], ref_reg} - {s_tdata[VOLT_W-1], s_tdata[VOLT_W-1:0]};
        end
    end

    // duty sum in Q.40 built up over the three later products
    always_comb begin
        sum_next = sum_reg;
        if (ctrl.sum_lo_load) begin
            sum_next = {24'd0, product[63:24]};
        end else if (ctrl.sum_hi_load) begin
            if ($signed(product[63:0]) > PROD_LIMIT) begin
                sum_next = SAT_POS;
            end else if ($signed(product[63:0]) < -PROD_LIMIT) begin
                sum_next = SAT_NEG;
            end else begin
                sum_next = {product[55:0], 8'd0} + sum_reg;
            end
        end else if (ctrl.sum_kp_load) begin
            sum_next = sum_reg + product[63:0];
        end
    end

    always_comb begin
        sum_above_one = $signed(sum_reg) > ONE_Q40;
        sum_negative  = sum_reg[INTEG_W-1];
    end

    always_comb begin
        integ_next    = integ_reg;
        duty_next     = duty_reg;
        lim_next      = lim_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (ctrl.finish) begin
            m_tvalid_next = 1'b1;
            if (sum_above_one) begin
                duty_next = DUTY_FULL;
                lim_next  = LIM_HIGH;
            end else if (sum_negative) begin
                duty_next = DUTY_ZERO;
                lim_next  = LIM_LOW;
            end else begin
                duty_next  = sum_reg[40:24];
                lim_next   = LIM_NONE;
                integ_next = integ_try_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg      <= RESET_REFERENCE;
            kp_reg       <= RESET_KP;
            ki_reg       <= RESET_KI;
            ts_reg       <= RESET_TIME_STEP;
            integ_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            ref_reg      <= ref_next;
            kp_reg       <= kp_next;
            ki_reg       <= ki_next;
            ts_reg       <= ts_next;
            integ_reg    <= integ_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg       <= err_next;
        integ_try_reg <= integ_try_next;
        sum_reg       <= sum_next;
        duty_reg      <= duty_next;
        lim_reg       <= lim_next;
    end

    assign s_tready = ctrl.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-DUTY_W){1'b0}}, duty_reg};
    assign m_tuser  = lim_reg;

    // a clamped result carries the matching limit duty
    a_clamp_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == LIM_HIGH) |-> m_tdata[DUTY_W-1:0] == DUTY_FULL)
        else $error("high clamp without full duty");

    a_clamp_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == LIM_LOW) |-> m_tdata[DUTY_W-1:0] == DUTY_ZERO)
        else $error("low clamp without zero duty");

    // the kept integral moves only when a result is committed
    a_integ_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(ctrl.finish) |-> $stable(integ_reg))
        else $error("integral changed outside commit");

    // the multiplier is never reloaded mid-product
    a_mult_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.mult_start |-> !mult_busy && state != ST_IDLE)
        else $error("multiplier started while busy");

endmodule

[tb/pi_controller_antiwindup_unit_tb.sv]
// ----------------------------------------------------------------------------
// pi_controller_antiwindup_unit_tb
// Self-checking bench for the PI controller with clamping anti-windup.
// ----------------------------------------------------------------------------
// Measurements go in on the slave stream and duty items come back on the
// master stream. A bit-exact fixed-point controller model in the bench
// predicts each duty item and its limit flag as the measurement is taken;
// a monitor compares every duty item in order. Tests cover the exact duty
// limits, register extremes, output backpressure that stalls the input,
// integral windup until the integral term saturates, and randomized gain
// settings with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module pi_controller_antiwindup_unit_tb;
    import piaw_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 1200;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [LIM_W-1:0]  lim;
    } duty_item_t;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [TDATA_IN_W-1:0]    s_tdata   = '0;     // [23:0] measured_voltage
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0]   m_tdata;            // [16:0] duty_cycle
    logic [LIM_W-1:0]         m_tuser;            // [1:0] limit_hit

    // controller model state and register copies
    longint      vref     = longint'(signed'(RESET_REFERENCE));
    logic [31:0] k_p      = RESET_KP;
    logic [31:0] k_i      = RESET_KI;
    logic [31:0] t_step   = RESET_TIME_STEP;
    longint      integ_acc = 0;

    duty_item_t duty_q[$];

    bit sender_idle = 1'b1;
    bit rx_idle     = 1'b1;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int stall_left  = 0;
    int quiet_cycles = 0;

    int mismatch_count = 0;
    int sent_count     = 0;
    int checked_count  = 0;
    int high_count     = 0;
    int low_count      = 0;

    pi_controller_antiwindup_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // one control sample: error, integral update, PI sum, clamp and restore
    function automatic duty_item_t predict_duty(input logic [23:0] meas_raw);
        longint             err, incr, prior, hi, a, i_term, sum;
        longint unsigned    lo_prod;
        logic [64:0]        wide;
        duty_item_t         res;
        err   = vref - longint'(signed'(meas_raw));
        incr  = (err * longint'(t_step)) >>> 8;
        prior = integ_acc;
        wide  = {prior[63], prior} + {incr[63], incr};
        if (wide[64] != wide[63]) begin
            integ_acc = wide[64] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_acc = wide[63:0];
        end
        // integral term from the high and low 32-bit halves of the integral
        hi      = integ_acc >>> 32;
        a       = longint'(k_i) * hi;
        lo_prod = 64'(k_i) * 64'(integ_acc[31:0]);
        if (a > PROD_LIMIT) begin
            i_term = SAT_POS;
        end else if (a < -PROD_LIMIT) begin
            i_term = SAT_NEG;
        end else begin
            i_term = a * 256 + longint'(lo_prod >> 24);
        end
        sum = err * longint'(k_p) + i_term;
        if (sum > ONE_Q40) begin
            res.duty  = DUTY_FULL;
            res.lim   = LIM_HIGH;
            integ_acc = prior;
        end else if (sum < 0) begin
            res.duty  = DUTY_ZERO;
            res.lim   = LIM_LOW;
            integ_acc = prior;
        end else begin
            res.duty = DUTY_W'(sum >>> 24);
            res.lim  = LIM_NONE;
        end
        return res;
    endfunction

    // writes all four registers back to back; the block must be idle
    task automatic program_regs(input logic [31:0] ref_w, kp_w, ki_w, ts_w);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_REFERENCE;
        cfg_wdata <= ref_w;
        @(posedge aclk);
        cfg_addr  <= REG_KP;
        cfg_wdata <= kp_w;
        @(posedge aclk);
        cfg_addr  <= REG_KI;
        cfg_wdata <= ki_w;
        @(posedge aclk);
        cfg_addr  <= REG_TIME_STEP;
        cfg_wdata <= ts_w;
        @(posedge aclk);
        cfg_we <= 1'b0;
        vref   = longint'(signed'(ref_w[23:0]));
        k_p    = kp_w;
        k_i    = ki_w;
        t_step = ts_w;
    endtask

    task automatic send_meas(input logic [23:0] meas);
        int gap_len;
        s_tvalid <= 1'b1;
        s_tdata  <= meas;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        duty_q.push_back(predict_duty(meas));
        sent_count++;
        if (sender_idle && $urandom_range(0, 2) == 0) begin
            gap_len = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap_len) @(posedge aclk);
        end
    endtask

    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (duty_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [23:0] near_reference();
        longint off;
        off = longint'($signed($urandom)) >>> $urandom_range(6, 31);
        return 24'(vref - off);
    endfunction

    task automatic test_directed_limits();
        // reset settings: zero error, both rails, in-range duty
        send_meas(RESET_REFERENCE);
        send_meas(24'h7F_FFFF);
        send_meas(24'h80_0000);
        send_meas(24'h00_0000);
        send_meas(24'h02_0000);
        settle_pipeline();
        // unity gain: exactly full duty, just above it, just below zero
        program_regs(32'h0000_0000, 32'h0100_0000, 32'h0, 32'h0);
        send_meas(24'hFF_0000);
        send_meas(24'hFE_FFFF);
        send_meas(24'hFF_0001);
        send_meas(24'h00_0000);
        send_meas(24'h00_0001);
        settle_pipeline();
        // lowest reference, upper write bits ignored, all gains zero
        program_regs(32'hFF80_0000, 32'h0, 32'h0, 32'h0);
        send_meas(24'h7F_FFFF);
        send_meas(24'h80_0000);
        settle_pipeline();
        program_regs(32'h007F_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_meas(24'h80_0000);
        send_meas(24'h7F_FFFF);
        send_meas(24'h7F_FFFE);
        settle_pipeline();
        program_regs(32'h007F_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_meas(24'h7F_FFFF);
        send_meas(24'h00_0000);
        settle_pipeline();
    endtask

    task automatic test_output_backpressure();
        program_regs({8'h0, RESET_REFERENCE}, RESET_KP, RESET_KI, RESET_TIME_STEP);
        sender_idle = 1'b0;
        hold_req    = 1'b1;
        repeat (6) send_meas(near_reference());
        settle_pipeline();
        sender_idle = 1'b1;
    endtask

    task automatic run_random_phase(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_meas(24'($urandom));
            end else begin
                send_meas(near_reference());
            end
            if ($urandom_range(0, 29) == 0) settle_pipeline();
        end
        settle_pipeline();
    endtask

    task automatic test_random_settings();
        program_regs({8'h0, RESET_REFERENCE}, RESET_KP, RESET_KI, RESET_TIME_STEP);
        run_random_phase(70);
        repeat (5) begin
            program_regs($urandom, $urandom >> $urandom_range(4, 31),
                         $urandom >> $urandom_range(0, 31),
                         $urandom >> $urandom_range(8, 31));
            run_random_phase(70);
        end
    endtask

    // integral gain off while the integral runs up, then full gain so the
    // integral term saturates and the duty clamps
    task automatic test_integral_windup();
        program_regs(32'h007F_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
        repeat (70) send_meas({16'h8000, 8'($urandom)});
        settle_pipeline();
        program_regs(32'h007F_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_meas(24'h00_0000);
        send_meas(24'h7F_FFFF);
        settle_pipeline();
        program_regs(32'h0080_0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
        repeat (140) send_meas({16'h7FFF, 8'($urandom)});
        settle_pipeline();
        program_regs(32'h0080_0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_meas(24'h00_0000);
        send_meas(24'h80_0000);
        settle_pipeline();
        // bring the integral back near zero
        program_regs(32'h007F_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
        repeat (70) send_meas({16'h8000, 8'($urandom)});
        settle_pipeline();
    endtask

    task automatic test_random_no_idle();
        program_regs($urandom, $urandom >> $urandom_range(4, 31),
                     $urandom >> $urandom_range(8, 31),
                     $urandom >> $urandom_range(8, 31));
        run_random_phase(40);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_limits();
        test_output_backpressure();
        test_random_settings();
        sender_idle = 1'b0;
        rx_idle     = 1'b0;
        test_integral_windup();
        test_random_no_idle();
        repeat (150) @(posedge aclk);
        if (duty_q.size() != 0) begin
            $error("%0d duty items never arrived", duty_q.size());
            mismatch_count++;
        end
        $display("sent %0d measurements, checked %0d duty items", sent_count, checked_count);
        $display("clamped high %0d, clamped low %0d, incl. integral term saturation",
                 high_count, low_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // result ready: random stall bursts plus one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // duty monitor and watchdog
    always @(posedge aclk) begin
        duty_item_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (m_tvalid && m_tready) begin
                if (duty_q.size() == 0) begin
                    $error("duty item with none expected: duty %0d limit %0d",
                           m_tdata[DUTY_W-1:0], m_tuser);
                    mismatch_count++;
                end else begin
                    want = duty_q.pop_front();
                    checked_count++;
                    if (want.lim == LIM_HIGH) high_count++;
                    if (want.lim == LIM_LOW) low_count++;
                    if (m_tdata[DUTY_W-1:0] !== want.duty) begin
                        $error("duty_cycle: expected %0d, got %0d",
                               want.duty, m_tdata[DUTY_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.lim) begin
                        $error("limit_hit: expected %0d, got %0d", want.lim, m_tuser);
                        mismatch_count++;
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule

[files.f]
design/piaw_pkg.sv
design/piaw_serial_mult.sv
design/piaw_seq.sv
design/pi_controller_antiwindup_unit.sv
tb/pi_controller_antiwindup_unit_tb.sv
